/* rtl/sprite_animation_sequencer_defines.svh */
// Assertion macros for the sprite animation sequencer.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
`define SAS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SAS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SAS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SAS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/spr_anim_pkg.sv */
// Shared types, constants and helpers of the sprite animation sequencer.
// No dependencies.
package spr_anim_pkg;

   localparam int DEF_MAX_STATES = 16;
   localparam int DEF_MAX_FRAMES = 256;

   localparam int KIND_W      = 2;
   localparam int STATE_W     = 4;
   localparam int FRAME_W     = 8;
   localparam int DIM_W       = 11;
   localparam int COLS_W      = 7;
   localparam int OFS_W       = 12;
   localparam int CNT_W       = 5;
   localparam int RECT_W      = 19;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_W       = 12;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 88;

   localparam logic [RECT_W-1:0] RECT_MAX = '1;

   localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd32;
   localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd32;
   localparam logic [COLS_W-1:0] RST_SHEET_COLS   = 7'd8;
   localparam logic [CNT_W-1:0]  RST_STATE_COUNT  = 5'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 2'd0,
      KIND_SELECT = 2'd1,
      KIND_LOAD   = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_SHEET_COLS   = 3'd2,
      CSR_OFFSET_X     = 3'd3,
      CSR_OFFSET_Y     = 3'd4,
      CSR_STATE_COUNT  = 3'd5,
      CSR_ADVANCE_ALL  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      TBL_NOP,
      TBL_ADVANCE,
      TBL_REWIND,
      TBL_LOAD
   } tbl_op_type;

   typedef struct packed {
      tbl_op_type         op;
      logic [FRAME_W-1:0] first;
      logic [FRAME_W-1:0] last;
   } tbl_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FETCH,
      ST_DIV,
      ST_MUL_X,
      ST_MUL_Y,
      ST_FIN
   } seq_state_type;

   function automatic logic [RECT_W-1:0] sat_rect(input logic [RECT_W+1:0] v);
      sat_rect = (v > {2'b00, RECT_MAX}) ? RECT_MAX : v[RECT_W-1:0];
   endfunction

endpackage

/* rtl/spr_anim_div.sv */
// Serial restoring divider: one quotient bit per cycle, frame index by column count.
// Depends on spr_anim_pkg.
module spr_anim_div
   import spr_anim_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [FRAME_W-1:0]  dividend,
   input  logic [COLS_W-1:0]   divisor,
   output logic                done,
   output logic [FRAME_W-1:0]  quot,
   output logic [COLS_W-1:0]   rem
);

   localparam int STEP_W = $clog2(FRAME_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [FRAME_W-1:0] dq_ff;
   logic [COLS_W-1:0]  rem_ff;
   logic [COLS_W-1:0]  dvs_ff;

   logic [COLS_W:0] trial;
   logic [COLS_W:0] diff;
   logic            ge;

   assign trial = {rem_ff, dq_ff[FRAME_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(FRAME_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= (divisor == '0) ? COLS_W'(1) : divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[COLS_W-1:0] : trial[COLS_W-1:0];
         dq_ff  <= {dq_ff[FRAME_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = dq_ff;
   assign rem  = rem_ff;

endmodule

/* rtl/spr_anim_table.sv */
// Animation state table: first, last and current frame per state, with step logic.
// Depends on spr_anim_pkg.
module spr_anim_table
   import spr_anim_pkg::*;
#(
   parameter  int MAX_STATES = DEF_MAX_STATES,
   parameter  int MAX_FRAMES = DEF_MAX_FRAMES,
   localparam int IW         = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  tbl_cmd_type        cmd,
   input  logic [IW-1:0]      wr_idx,
   input  logic [IW-1:0]      rd_idx,
   output logic [FRAME_W-1:0] rd_frame
);

   localparam int FRAME_LIM = (1 << FRAME_W) - 1;
   localparam int FRAME_TOP = (MAX_FRAMES - 1 > FRAME_LIM) ? FRAME_LIM : MAX_FRAMES - 1;

   logic [FRAME_W-1:0] first_ff [MAX_STATES];
   logic [FRAME_W-1:0] last_ff  [MAX_STATES];
   logic [FRAME_W-1:0] cur_ff   [MAX_STATES];

   logic [FRAME_W:0]   step;
   logic [FRAME_W-1:0] first_clamp;
   logic [FRAME_W-1:0] last_clamp;

   assign step        = {1'b0, cur_ff[wr_idx]} + 1'b1;
   assign first_clamp = (cmd.first > FRAME_W'(FRAME_TOP)) ? FRAME_W'(FRAME_TOP) : cmd.first;
   assign last_clamp  = (cmd.last > FRAME_W'(FRAME_TOP)) ? FRAME_W'(FRAME_TOP) : cmd.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_STATES; i++) begin
            first_ff[i] <= '0;
            last_ff[i]  <= '0;
            cur_ff[i]   <= '0;
         end
      end else begin
         case (cmd.op)
            TBL_ADVANCE: begin
               cur_ff[wr_idx] <= (step > {1'b0, last_ff[wr_idx]}) ? first_ff[wr_idx]
                                                                   : step[FRAME_W-1:0];
            end
            TBL_REWIND: begin
               cur_ff[wr_idx] <= first_ff[wr_idx];
            end
            TBL_LOAD: begin
               first_ff[wr_idx] <= first_clamp;
               last_ff[wr_idx]  <= last_clamp;
               cur_ff[wr_idx]   <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rd_frame = cur_ff[rd_idx];

endmodule

/* rtl/sprite_animation_sequencer.sv */
// Sprite animation sequencer top: config registers, item sequencer, shared multiplier.
// Depends on spr_anim_pkg, spr_anim_table, spr_anim_div and the defines header.
//
//  Channel  Dir  Handshake             Beat contents
//  req      in   req_tvalid/tready     tuser: kind; tdata: target, first, last frame
//  rsp      out  rsp_tvalid/tready     tuser: status; tdata: state, frame, rectangle
//  csr      in   csr_we                csr_index selects register, csr_wdata value
//
// An item passes from accept through the table update, the serial divider (8 steps) and
// the X and Y multiplies to the result; an all-states tick first walks each state in use.
// One item at a time; req_tready is high only while the sequencer is idle.
// A result waits in the output register; the next item is accepted meanwhile.
// Synchronous active-high reset clears the table and current state and loads register defaults.
`include "sprite_animation_sequencer_defines.svh"

module sprite_animation_sequencer
   import spr_anim_pkg::*;
#(
   parameter  int MAX_STATES = DEF_MAX_STATES,
   parameter  int MAX_FRAMES = DEF_MAX_FRAMES,
   localparam int IW         = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // target_state, first_frame, last_frame
   input  logic [KIND_W-1:0]      req_tuser,   // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // state_now, frame_now, rect_left,
                                               // rect_top, rect_right, rect_bottom
   output logic [0:0]             rsp_tuser,   // status
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   seq_state_type state_ff, state_in;

   logic [DIM_W-1:0]  fw_ff, fh_ff;
   logic [COLS_W-1:0] cols_ff;
   logic [OFS_W-1:0]  offx_ff, offy_ff;
   logic [CNT_W-1:0]  scount_ff;
   logic              all_ff;

   kind_type           kind_ff;
   logic [STATE_W-1:0] tgt_ff;
   logic [FRAME_W-1:0] first_ff, last_ff;

   logic [STATE_W-1:0] cur_state_ff;
   logic [CNT_W-1:0]   scan_cnt_ff;
   logic               status_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [RECT_W-1:0]  prod_ff;
   logic [RECT_W:0]    left_raw_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_status_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [CNT_W-1:0] states_used;
   logic             sel_ok, load_ok;
   logic             req_fire, out_load;

   tbl_cmd_type        tbl_cmd;
   logic [IW-1:0]      tbl_idx;
   logic [FRAME_W-1:0] rd_frame;

   logic               div_start, div_done;
   logic [FRAME_W-1:0] div_quot;
   logic [COLS_W-1:0]  div_rem;

   logic [FRAME_W-1:0] mul_a;
   logic [DIM_W-1:0]   mul_b;
   logic [RECT_W-1:0]  mul_p;

   logic [RECT_W:0]   top_raw;
   logic [RECT_W+1:0] right_raw, bottom_raw;

   assign states_used = (32'(scount_ff) > MAX_STATES) ? CNT_W'(MAX_STATES) : scount_ff;
   assign sel_ok      = {1'b0, tgt_ff} < states_used;
   assign load_ok     = 32'(tgt_ff) < MAX_STATES;
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign out_load    = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (kind_ff == KIND_TICK && all_ff && states_used != '0) state_in = ST_SCAN;
            else state_in = ST_FETCH;
         end
         ST_SCAN:  if (scan_cnt_ff + 1'b1 == states_used) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_MUL_X;
         ST_MUL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_FIN;
         ST_FIN:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      tbl_cmd.op    = TBL_NOP;
      tbl_cmd.first = first_ff;
      tbl_cmd.last  = last_ff;
      tbl_idx       = IW'(cur_state_ff);
      div_start     = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            case (kind_ff)
               KIND_TICK: if (!all_ff) tbl_cmd.op = TBL_ADVANCE;
               KIND_SELECT: begin
                  if (sel_ok) begin
                     tbl_cmd.op = TBL_REWIND;
                     tbl_idx    = IW'(tgt_ff);
                  end
               end
               KIND_LOAD: begin
                  if (load_ok) begin
                     tbl_cmd.op = TBL_LOAD;
                     tbl_idx    = IW'(tgt_ff);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            tbl_cmd.op = TBL_ADVANCE;
            tbl_idx    = IW'(scan_cnt_ff);
         end
         ST_FETCH: div_start = 1'b1;
         default: begin
         end
      endcase
   end

   assign mul_a = (state_ff == ST_MUL_X) ? FRAME_W'(div_rem) : div_quot;
   assign mul_b = (state_ff == ST_MUL_X) ? fw_ff : fh_ff;
   assign mul_p = RECT_W'(mul_a) * RECT_W'(mul_b);

   assign top_raw    = (RECT_W+1)'(prod_ff) + (RECT_W+1)'(offy_ff);
   assign right_raw  = (RECT_W+2)'(left_raw_ff) + (RECT_W+2)'(fw_ff);
   assign bottom_raw = (RECT_W+2)'(top_raw) + (RECT_W+2)'(fh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_state_ff <= '0;
         rsp_valid_ff <= 1'b0;
         fw_ff        <= RST_FRAME_WIDTH;
         fh_ff        <= RST_FRAME_HEIGHT;
         cols_ff      <= RST_SHEET_COLS;
         offx_ff      <= '0;
         offy_ff      <= '0;
         scount_ff    <= RST_STATE_COUNT;
         all_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  fw_ff     <= csr_wdata[DIM_W-1:0];
               CSR_FRAME_HEIGHT: fh_ff     <= csr_wdata[DIM_W-1:0];
               CSR_SHEET_COLS:   cols_ff   <= csr_wdata[COLS_W-1:0];
               CSR_OFFSET_X:     offx_ff   <= csr_wdata[OFS_W-1:0];
               CSR_OFFSET_Y:     offy_ff   <= csr_wdata[OFS_W-1:0];
               CSR_STATE_COUNT:  scount_ff <= csr_wdata[CNT_W-1:0];
               CSR_ADVANCE_ALL:  all_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_EXEC && kind_ff == KIND_SELECT && sel_ok) cur_state_ff <= tgt_ff;
         rsp_valid_ff <= out_load || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff  <= kind_type'(req_tuser);
         tgt_ff   <= req_tdata[3:0];
         first_ff <= req_tdata[11:4];
         last_ff  <= req_tdata[19:12];
      end
      case (state_ff)
         ST_EXEC: begin
            status_ff   <= (kind_ff == KIND_SELECT && !sel_ok) ||
                           (kind_ff == KIND_LOAD && !load_ok);
            scan_cnt_ff <= '0;
         end
         ST_SCAN:  scan_cnt_ff <= scan_cnt_ff + 1'b1;
         ST_FETCH: frame_ff <= rd_frame;
         ST_MUL_X: prod_ff <= mul_p;
         ST_MUL_Y: begin
            prod_ff     <= mul_p;
            left_raw_ff <= (RECT_W+1)'(prod_ff) + (RECT_W+1)'(offx_ff);
         end
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= {sat_rect(bottom_raw), sat_rect(right_raw),
                           sat_rect({1'b0, top_raw}), sat_rect({1'b0, left_raw_ff}),
                           frame_ff, cur_state_ff};
      end
   end

   spr_anim_table #(
      .MAX_STATES (MAX_STATES),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .wr_idx   (tbl_idx),
      .rd_idx   (IW'(cur_state_ff)),
      .rd_frame (rd_frame)
   );

   spr_anim_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_frame),
      .divisor  (cols_ff),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   `SAS_ASSERT_NXT(a_accept_exec, clock, reset, req_fire, state_ff == ST_EXEC, "accept did not start")
   `SAS_ASSERT_IMP(a_div_in_wait, clock, reset, div_done, state_ff == ST_DIV, "divider done out of step")
   `SAS_ASSERT_IMP(a_cur_bound, clock, reset, 1'b1, 32'(cur_state_ff) < MAX_STATES, "state index out of table")
   `SAS_ASSERT_IMP(a_status_kind, clock, reset, (state_ff == ST_FIN) && status_ff, (kind_ff == KIND_SELECT) || (kind_ff == KIND_LOAD), "status on wrong kind")

endmodule

/* tb/anim_rect_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the sprite animation sequencer: mirrors the registers, state table and
// selected state, predicts each response beat and compares it field by field.
// Depends on spr_anim_pkg.
module anim_rect_checker
   import spr_anim_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // target_state, first_frame, last_frame
   input  logic [KIND_W-1:0]      req_tuser,   // kind
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // state_now, frame_now, rect_left,
                                               // rect_top, rect_right, rect_bottom
   input  logic [0:0]             rsp_tuser,   // status
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   output int                     mismatch_count,
   output int                     rects_pending
);

   typedef struct packed {
      logic               status;
      logic [STATE_W-1:0] state_now;
      logic [FRAME_W-1:0] frame_now;
      logic [RECT_W-1:0]  left;
      logic [RECT_W-1:0]  top;
      logic [RECT_W-1:0]  right;
      logic [RECT_W-1:0]  bottom;
   } anim_rect_t;

   logic [DIM_W-1:0]   frame_w;
   logic [DIM_W-1:0]   frame_h;
   logic [COLS_W-1:0]  sheet_cols;
   logic [OFS_W-1:0]   ofs_x;
   logic [OFS_W-1:0]   ofs_y;
   logic [CNT_W-1:0]   state_cnt;
   logic               adv_all;

   logic [FRAME_W-1:0] first_tab [DEF_MAX_STATES];
   logic [FRAME_W-1:0] last_tab  [DEF_MAX_STATES];
   logic [FRAME_W-1:0] cur_tab   [DEF_MAX_STATES];
   logic [STATE_W-1:0] sel_state;

   anim_rect_t rect_expected [$];
   anim_rect_t want;
   anim_rect_t got;

   initial begin
      mismatch_count = 0;
      rects_pending  = 0;
   end

   function automatic logic [RECT_W-1:0] clip_rect(input int v);
      clip_rect = (v > RECT_MAX) ? RECT_MAX : v[RECT_W-1:0];
   endfunction

   task automatic bump_frame(input int idx);
      logic [FRAME_W:0] nxt;
      nxt = {1'b0, cur_tab[idx]} + 1'b1;
      cur_tab[idx] = (nxt > {1'b0, last_tab[idx]}) ? first_tab[idx] : nxt[FRAME_W-1:0];
   endtask

   task automatic apply_item(input logic [KIND_W-1:0] kind, input logic [STATE_W-1:0] tgt,
                             input logic [FRAME_W-1:0] start_fr,
                             input logic [FRAME_W-1:0] end_fr, output anim_rect_t res);
      int in_use;
      int i;
      int cols;
      int frame;
      int left;
      int top;
      in_use = (state_cnt > DEF_MAX_STATES) ? DEF_MAX_STATES : state_cnt;
      res.status = 1'b0;
      case (kind)
         KIND_TICK: begin
            if (adv_all) begin
               for (i = 0; i < in_use; i++) bump_frame(i);
            end else begin
               bump_frame(sel_state);
            end
         end
         KIND_SELECT: begin
            if (tgt < in_use) begin
               sel_state    = tgt;
               cur_tab[tgt] = first_tab[tgt];
            end else begin
               res.status = 1'b1;
            end
         end
         KIND_LOAD: begin
            // 4-bit index and 8-bit frames never exceed the table or frame limits
            first_tab[tgt] = start_fr;
            last_tab[tgt]  = end_fr;
            cur_tab[tgt]   = '0;
         end
         default: ;
      endcase
      frame = cur_tab[sel_state];
      cols  = (sheet_cols == 0) ? 1 : sheet_cols;
      left  = (frame % cols) * frame_w + ofs_x;
      top   = (frame / cols) * frame_h + ofs_y;
      res.state_now = sel_state;
      res.frame_now = frame[FRAME_W-1:0];
      res.left      = clip_rect(left);
      res.top       = clip_rect(top);
      res.right     = clip_rect(left + frame_w);
      res.bottom    = clip_rect(top + frame_h);
   endtask

   task automatic check_field(input string field, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_w    = RST_FRAME_WIDTH;
         frame_h    = RST_FRAME_HEIGHT;
         sheet_cols = RST_SHEET_COLS;
         ofs_x      = '0;
         ofs_y      = '0;
         state_cnt  = RST_STATE_COUNT;
         adv_all    = 1'b0;
         for (int i = 0; i < DEF_MAX_STATES; i++) begin
            first_tab[i] = '0;
            last_tab[i]  = '0;
            cur_tab[i]   = '0;
         end
         sel_state = '0;
         rect_expected.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rsp_tuser[0];
            got.state_now = rsp_tdata[3:0];
            got.frame_now = rsp_tdata[11:4];
            got.left      = rsp_tdata[30:12];
            got.top       = rsp_tdata[49:31];
            got.right     = rsp_tdata[68:50];
            got.bottom    = rsp_tdata[87:69];
            if (rect_expected.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, got status %0d state %0d frame %0d",
                        $time, got.status, got.state_now, got.frame_now);
               mismatch_count++;
            end else begin
               want = rect_expected.pop_front();
               check_field("status", want.status, got.status);
               check_field("state_now", want.state_now, got.state_now);
               check_field("frame_now", want.frame_now, got.frame_now);
               check_field("rect_left", want.left, got.left);
               check_field("rect_top", want.top, got.top);
               check_field("rect_right", want.right, got.right);
               check_field("rect_bottom", want.bottom, got.bottom);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_item(req_tuser, req_tdata[3:0], req_tdata[11:4], req_tdata[19:12], want);
            rect_expected.push_back(want);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_w    = csr_wdata[DIM_W-1:0];
               CSR_FRAME_HEIGHT: frame_h    = csr_wdata[DIM_W-1:0];
               CSR_SHEET_COLS:   sheet_cols = csr_wdata[COLS_W-1:0];
               CSR_OFFSET_X:     ofs_x      = csr_wdata[OFS_W-1:0];
               CSR_OFFSET_Y:     ofs_y      = csr_wdata[OFS_W-1:0];
               CSR_STATE_COUNT:  state_cnt  = csr_wdata[CNT_W-1:0];
               CSR_ADVANCE_ALL:  adv_all    = csr_wdata[0];
               default: ;
            endcase
         end
      end
      rects_pending <= rect_expected.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the sprite animation sequencer bench: clock, reset, register programming,
// request beats and response back-pressure, verdict. Uses spr_anim_pkg and anim_rect_checker.
module testbench;
   import spr_anim_pkg::*;

   localparam logic [KIND_W-1:0]    KIND_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE      = 3'd7;
   localparam int                   PHASES        = 12;
   localparam int                   PHASE_ITEMS   = 153;
   localparam int                   SETTLE_CYCLES = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_W-1:0]       csr_wdata;
   int                     mismatch_count;
   int                     rects_pending;

   logic                   no_gaps;
   int                     cur_count;

   sprite_animation_sequencer u_top (.*);
   anim_rect_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // response side back-pressure
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [STATE_W-1:0] tgt,
                            input logic [FRAME_W-1:0] start_fr,
                            input logic [FRAME_W-1:0] end_fr);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, end_fr, start_fr, tgt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (rects_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
   endtask

   task automatic configure(input int fw, input int fh, input int cols, input int ox,
                            input int oy, input int cnt, input int adv);
      drain();
      write_reg(CSR_FRAME_WIDTH, fw);
      write_reg(CSR_FRAME_HEIGHT, fh);
      write_reg(CSR_SHEET_COLS, cols);
      write_reg(CSR_OFFSET_X, ox);
      write_reg(CSR_OFFSET_Y, oy);
      write_reg(CSR_STATE_COUNT, cnt);
      write_reg(CSR_ADVANCE_ALL, adv);
      @(negedge clock) csr_we <= 1'b0;
      cur_count = cnt;
   endtask

   function automatic int pick_val(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 3);
      pick_val = (r == 0) ? lo : (r == 1) ? hi : $urandom_range(lo, hi);
   endfunction

   task automatic random_item();
      int r;
      int in_use;
      int tgt;
      int start_fr;
      int end_fr;
      logic [STATE_W-1:0] tgt_v;
      logic [FRAME_W-1:0] start_v;
      logic [FRAME_W-1:0] end_v;
      r      = $urandom_range(0, 99);
      in_use = (cur_count > DEF_MAX_STATES) ? DEF_MAX_STATES : cur_count;
      if (in_use == 0 || $urandom_range(0, 9) == 0) tgt = $urandom_range(0, 15);
      else tgt = $urandom_range(0, in_use - 1);
      start_fr = $urandom_range(0, 255);
      if ($urandom_range(0, 4) == 0) end_fr = $urandom_range(0, 255);
      else end_fr = start_fr + $urandom_range(0, 6);
      if (end_fr > 255) end_fr = 255;
      tgt_v   = STATE_W'(tgt);
      start_v = FRAME_W'(start_fr);
      end_v   = FRAME_W'(end_fr);
      if (r < 50) send_item(KIND_TICK, tgt_v, start_v, end_v);
      else if (r < 70) send_item(KIND_SELECT, tgt_v, start_v, end_v);
      else if (r < 96) send_item(KIND_LOAD, tgt_v, start_v, end_v);
      else send_item(KIND_UNUSED, tgt_v, start_v, end_v);
   endtask

   initial begin
      int cnt;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_TICK;
      csr_we     = 1'b0;
      csr_index  = CSR_FRAME_WIDTH;
      csr_wdata  = '0;
      no_gaps    = 1'b0;
      cur_count  = RST_STATE_COUNT;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset settings: one state in use
      send_item(KIND_TICK, 4'd0, 8'd0, 8'd0);
      send_item(KIND_SELECT, 4'd0, 8'd0, 8'd0);
      send_item(KIND_SELECT, 4'd1, 8'd0, 8'd0);
      send_item(KIND_LOAD, 4'd0, 8'd0, 8'd255);
      send_item(KIND_TICK, 4'd0, 8'd0, 8'd0);
      send_item(KIND_TICK, 4'd0, 8'd0, 8'd0);
      send_item(KIND_LOAD, 4'd15, 8'd255, 8'd255);
      send_item(KIND_LOAD, 4'd1, 8'd10, 8'd5);
      send_item(KIND_UNUSED, 4'd15, 8'd255, 8'd255);
      send_item(KIND_SELECT, 4'd0, 8'd0, 8'd0);

      // widest grid, zero columns, saturating rectangle, all-states ticks
      configure(2047, 2047, 0, 4095, 4095, 16, 1);
      write_reg(CSR_NONE, 4095);
      @(negedge clock) csr_we <= 1'b0;
      send_item(KIND_SELECT, 4'd1, 8'd0, 8'd0);
      send_item(KIND_TICK, 4'd0, 8'd0, 8'd0);
      send_item(KIND_SELECT, 4'd15, 8'd0, 8'd0);
      send_item(KIND_TICK, 4'd0, 8'd0, 8'd0);
      send_item(KIND_SELECT, 4'd0, 8'd0, 8'd0);
      send_item(KIND_TICK, 4'd0, 8'd0, 8'd0);

      // no states in use
      configure(1, 1, 1, 0, 0, 0, 0);
      send_item(KIND_SELECT, 4'd0, 8'd0, 8'd0);
      send_item(KIND_TICK, 4'd0, 8'd0, 8'd0);
      configure(1, 1, 1, 0, 0, 0, 1);
      send_item(KIND_TICK, 4'd0, 8'd0, 8'd0);

      // count above the table size
      configure(1024, 1024, 64, 0, 0, 31, 1);
      send_item(KIND_TICK, 4'd0, 8'd0, 8'd0);
      send_item(KIND_SELECT, 4'd15, 8'd0, 8'd0);
      send_item(KIND_LOAD, 4'd15, 8'd0, 8'd3);
      send_item(KIND_TICK, 4'd0, 8'd0, 8'd0);

      for (int p = 0; p < PHASES; p++) begin
         if ($urandom_range(0, 4) == 0) cnt = pick_val(0, 31);
         else cnt = pick_val(1, 16);
         configure(pick_val(0, 2047), pick_val(0, 2047),
                   ($urandom_range(0, 4) == 0) ? pick_val(0, 127) : pick_val(1, 64),
                   pick_val(0, 4095), pick_val(0, 4095), cnt, $urandom_range(0, 1));
         no_gaps = (p % 4 == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      end

      drain();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
